// ----- rtl/core/ttb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants and types for the triangle tangent basis core.
// ----------------------------------------------------------------------------
package ttb_pkg;

    // Width of every coordinate port and every result vector component port.
    localparam int IO_WIDTH = 32;

    // Default fixed-point format (Q16.16).
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Step codes of the per-triangle sequence.
    localparam logic [2:0] STEP_DET    = 3'd0;
    localparam logic [2:0] STEP_TAN_X  = 3'd1;
    localparam logic [2:0] STEP_BIT_X  = 3'd4;
    localparam logic [2:0] STEP_LAST   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIFF,
        ST_DIV,
        ST_OUT
    } ttb_state_t;

endpackage

// ----- rtl/core/ttb_serial_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_serial_mul
// Signed shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ttb_serial_mul #(
    parameter int EW = ttb_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [EW-1:0] op_a,
    input  logic signed [EW-1:0] op_b,
    output logic                 busy,
    output logic                 done,
    output logic signed [2*EW:0] prod
);
    localparam int CW = (EW > 1) ? $clog2(EW) : 1;
    localparam logic [CW-1:0] LAST = CW'(EW - 1);

    logic [EW-1:0]   mag_a_reg;
    logic [2*EW-1:0] acc_reg;
    logic            neg_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [EW:0]     upper_sum;

    // Upper half plus the multiplicand when the current multiplier bit is set.
    assign upper_sum = {1'b0, acc_reg[2*EW-1:EW]} + (acc_reg[0] ? {1'b0, mag_a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= op_a[EW-1] ? EW'(-op_a) : EW'(op_a);
            acc_reg   <= {{EW{1'b0}}, (op_b[EW-1] ? EW'(-op_b) : EW'(op_b))};
            neg_reg   <= op_a[EW-1] ^ op_b[EW-1];
        end
        else if (busy_reg)
        begin
            acc_reg <= {upper_sum, acc_reg[EW-1:1]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

// ----- rtl/core/ttb_serial_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_serial_div
// Restoring divider on magnitudes, one quotient bit per cycle, with a sticky
// flag for quotient bits beyond the kept width.
// ----------------------------------------------------------------------------
module ttb_serial_div #(
    parameter int DW = 2 * ttb_pkg::COORD_WIDTH_DEF + 4,
    parameter int FB = ttb_pkg::FRAC_BITS_DEF,
    parameter int QW = ttb_pkg::COORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num_mag,
    input  logic [DW-1:0] den_mag,
    output logic          done,
    output logic [QW-1:0] quot,
    output logic          ovf
);
    localparam int NB = DW + FB;
    localparam int CW = $clog2(NB);
    localparam logic [CW-1:0] LAST = CW'(NB - 1);

    logic [NB-1:0] num_sh_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quot_reg;
    logic          ovf_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          fits;

    assign trial     = {rem_reg, num_sh_reg[NB-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_sh_reg <= {num_mag, {FB{1'b0}}};
            den_reg    <= den_mag;
            rem_reg    <= '0;
            quot_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_sh_reg <= {num_sh_reg[NB-2:0], 1'b0};
            rem_reg    <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
            ovf_reg    <= ovf_reg | quot_reg[QW-1];
            quot_reg   <= {quot_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ----- rtl/core/triangle_tangent_basis_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_basis_core
// Per-triangle tangent and bitangent from vertex positions and texture
// coordinates, computed with a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//
// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// vertex   | vtx_valid, vtx_stall, pos_x..z, tex_u/v  | in
// result   | res_valid, res_stall, tangent_*,         | out
//          | bitangent_*, degenerate, saturated       |
//
// The first two vertices of a triangle are held and give no transaction. The
// third starts seven steps: the determinant, then the six components. Each
// step passes through a launch state, two serial multiplies and a difference
// state; a component step adds a serial divide. The default format is Q16.16.
// A zero determinant ends the sequence after the first step. Reset clears
// the held vertices and the slot counter. A stalled result waits in the
// output register while the next triangle's vertices are taken.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_core #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vtx_valid,
    output logic                               vtx_stall,
    input  logic [ttb_pkg::IO_WIDTH-1:0]        pos_x,
    input  logic [ttb_pkg::IO_WIDTH-1:0]        pos_y,
    input  logic [ttb_pkg::IO_WIDTH-1:0]        pos_z,
    input  logic [ttb_pkg::IO_WIDTH-1:0]        tex_u,
    input  logic [ttb_pkg::IO_WIDTH-1:0]        tex_v,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] tangent_x,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] tangent_y,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] tangent_z,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] bitangent_x,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] bitangent_y,
    output logic signed [ttb_pkg::IO_WIDTH-1:0] bitangent_z,
    output logic                               degenerate,
    output logic                               saturated
);
    localparam int W  = COORD_WIDTH;
    localparam int EW = W + 1;           // edge width
    localparam int PW = 2 * EW + 1;      // signed product width
    localparam int DW = PW + 1;          // signed difference width
    localparam int OW = ttb_pkg::IO_WIDTH;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MAX_NEG = {1'b1, {(W-1){1'b0}}};

    ttb_pkg::ttb_state_t state_reg, state_next;

    logic [OW-1:0]        vin [5];
    logic [OW-1:0]        held_pos_reg [6];
    logic [OW-1:0]        held_tex_reg [4];
    logic [1:0]           vertex_slot_reg;
    logic signed [EW-1:0] dp1_reg [3];
    logic signed [EW-1:0] dp2_reg [3];
    logic signed [EW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [2:0]           step_reg;
    logic signed [PW-1:0] prod_a_reg;
    logic                 num_neg_reg;
    logic [DW-1:0]        num_mag_reg;
    logic                 det_neg_reg;
    logic [DW-1:0]        det_mag_reg;
    logic signed [W-1:0]  comp_reg [6];
    logic                 sat_reg;
    logic                 degen_reg;
    logic                 res_valid_reg;
    logic signed [OW-1:0] res_comp_reg [6];
    logic                 res_degen_reg;
    logic                 res_sat_reg;

    logic                 vtx_accept;
    logic                 third_vertex;
    logic                 out_free;
    logic                 mul_start, mul_busy, mul_done;
    logic signed [EW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_prod;
    logic signed [DW-1:0] diff;
    logic                 div_start, div_done, div_ovf;
    logic [W-1:0]         div_quot;
    logic                 comp_neg, comp_clamp;
    logic [W-1:0]         comp_limit, comp_mag;
    logic [1:0]           axis;

    assign vin[0] = pos_x;
    assign vin[1] = pos_y;
    assign vin[2] = pos_z;
    assign vin[3] = tex_u;
    assign vin[4] = tex_v;

    assign vtx_stall    = (state_reg != ttb_pkg::ST_IDLE);
    assign vtx_accept   = vtx_valid && !vtx_stall;
    assign third_vertex = vertex_slot_reg[1];
    assign out_free     = !res_valid_reg || !res_stall;

    // Operand selection. The second product of a step is chosen while the
    // first one finishes, so the select follows the MUL_A state.
    always_comb
    begin
        axis = 2'd0;
        if (step_reg >= ttb_pkg::STEP_BIT_X)
        begin
            axis = 2'(step_reg - ttb_pkg::STEP_BIT_X);
        end
        else if (step_reg >= ttb_pkg::STEP_TAN_X)
        begin
            axis = 2'(step_reg - ttb_pkg::STEP_TAN_X);
        end
        if (step_reg == ttb_pkg::STEP_DET)
        begin
            mul_a = (state_reg == ttb_pkg::ST_MUL_A) ? dv1_reg : du1_reg;
            mul_b = (state_reg == ttb_pkg::ST_MUL_A) ? du2_reg : dv2_reg;
        end
        else if (step_reg < ttb_pkg::STEP_BIT_X)
        begin
            mul_a = (state_reg == ttb_pkg::ST_MUL_A) ? dp2_reg[axis] : dp1_reg[axis];
            mul_b = (state_reg == ttb_pkg::ST_MUL_A) ? dv1_reg : dv2_reg;
        end
        else
        begin
            mul_a = (state_reg == ttb_pkg::ST_MUL_A) ? dp1_reg[axis] : dp2_reg[axis];
            mul_b = (state_reg == ttb_pkg::ST_MUL_A) ? du2_reg : du1_reg;
        end
    end

    ttb_serial_mul #(
        .EW (EW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    ttb_serial_div #(
        .DW (DW),
        .FB (FRAC_BITS),
        .QW (W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (num_mag_reg),
        .den_mag (det_mag_reg),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    // Difference of the two products of the current step.
    assign diff = DW'(prod_a_reg) - DW'(mul_prod);

    // Sign, clamp and magnitude of a finished quotient.
    assign comp_neg   = (num_neg_reg ^ det_neg_reg) && ((div_quot != '0) || div_ovf);
    assign comp_limit = comp_neg ? MAX_NEG : MAX_POS;
    assign comp_clamp = div_ovf || (div_quot > comp_limit);
    assign comp_mag   = comp_clamp ? comp_limit : div_quot;

    // Next state. Every step enters through the launch state, so the first
    // product always sees the edges and the step code of that step.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                if (vtx_accept && third_vertex)
                begin
                    state_next = ttb_pkg::ST_LAUNCH;
                end
            end
            ttb_pkg::ST_LAUNCH:
            begin
                state_next = ttb_pkg::ST_MUL_A;
            end
            ttb_pkg::ST_MUL_A:
            begin
                if (mul_done)
                begin
                    state_next = ttb_pkg::ST_MUL_B;
                end
            end
            ttb_pkg::ST_MUL_B:
            begin
                if (mul_done)
                begin
                    state_next = ttb_pkg::ST_DIFF;
                end
            end
            ttb_pkg::ST_DIFF:
            begin
                if (step_reg == ttb_pkg::STEP_DET)
                begin
                    state_next = (num_mag_reg == '0) ? ttb_pkg::ST_OUT : ttb_pkg::ST_LAUNCH;
                end
                else
                begin
                    state_next = ttb_pkg::ST_DIV;
                end
            end
            ttb_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (step_reg == ttb_pkg::STEP_LAST) ? ttb_pkg::ST_OUT
                                                                  : ttb_pkg::ST_LAUNCH;
                end
            end
            ttb_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ttb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    // Unit start pulses.
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ttb_pkg::ST_LAUNCH:
            begin
                mul_start = 1'b1;
            end
            ttb_pkg::ST_MUL_A:
            begin
                mul_start = mul_done;
            end
            ttb_pkg::ST_DIFF:
            begin
                div_start = (step_reg != ttb_pkg::STEP_DET);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ttb_pkg::ST_IDLE;
            vertex_slot_reg <= '0;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                held_pos_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                held_tex_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (vtx_accept)
            begin
                if (third_vertex)
                begin
                    vertex_slot_reg <= '0;
                end
                else
                begin
                    vertex_slot_reg <= vertex_slot_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        held_pos_reg[3 * vertex_slot_reg[0] + i] <= vin[i];
                    end
                    held_tex_reg[2 * vertex_slot_reg[0]]     <= vin[3];
                    held_tex_reg[2 * vertex_slot_reg[0] + 1] <= vin[4];
                end
            end
            if (state_reg == ttb_pkg::ST_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ttb_pkg::ST_IDLE && vtx_accept && third_vertex)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp1_reg[i] <= EW'($signed(held_pos_reg[3 + i][W-1:0]))
                            - EW'($signed(held_pos_reg[i][W-1:0]));
                dp2_reg[i] <= EW'($signed(vin[i][W-1:0]))
                            - EW'($signed(held_pos_reg[i][W-1:0]));
            end
            du1_reg <= EW'($signed(held_tex_reg[2][W-1:0])) - EW'($signed(held_tex_reg[0][W-1:0]));
            dv1_reg <= EW'($signed(held_tex_reg[3][W-1:0])) - EW'($signed(held_tex_reg[1][W-1:0]));
            du2_reg <= EW'($signed(vin[3][W-1:0])) - EW'($signed(held_tex_reg[0][W-1:0]));
            dv2_reg <= EW'($signed(vin[4][W-1:0])) - EW'($signed(held_tex_reg[1][W-1:0]));
            step_reg  <= ttb_pkg::STEP_DET;
            sat_reg   <= 1'b0;
            degen_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                comp_reg[i] <= '0;
            end
        end
        if (state_reg == ttb_pkg::ST_MUL_A && mul_done)
        begin
            prod_a_reg <= mul_prod;
        end
        if (state_reg == ttb_pkg::ST_MUL_B && mul_done)
        begin
            num_neg_reg <= diff[DW-1];
            num_mag_reg <= diff[DW-1] ? DW'(-diff) : DW'(diff);
        end
        if (state_reg == ttb_pkg::ST_DIFF && step_reg == ttb_pkg::STEP_DET)
        begin
            det_neg_reg <= num_neg_reg;
            det_mag_reg <= num_mag_reg;
            if (num_mag_reg == '0)
            begin
                degen_reg <= 1'b1;
            end
            else
            begin
                step_reg <= ttb_pkg::STEP_TAN_X;
            end
        end
        if (state_reg == ttb_pkg::ST_DIV && div_done)
        begin
            comp_reg[step_reg - ttb_pkg::STEP_TAN_X] <= comp_neg ? $signed(-comp_mag)
                                                                 : $signed(comp_mag);
            sat_reg <= sat_reg | comp_clamp;
            if (step_reg != ttb_pkg::STEP_LAST)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
        if (state_reg == ttb_pkg::ST_OUT && out_free)
        begin
            for (int i = 0; i < 6; i++)
            begin
                res_comp_reg[i] <= OW'(comp_reg[i]);
            end
            res_degen_reg <= degen_reg;
            res_sat_reg   <= sat_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign tangent_x   = res_comp_reg[0];
    assign tangent_y   = res_comp_reg[1];
    assign tangent_z   = res_comp_reg[2];
    assign bitangent_x = res_comp_reg[3];
    assign bitangent_y = res_comp_reg[4];
    assign bitangent_z = res_comp_reg[5];
    assign degenerate  = res_degen_reg;
    assign saturated   = res_sat_reg;

    // A degenerate triangle carries zero vectors and no saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && degenerate |-> !saturated && tangent_x == '0 && bitangent_z == '0)
        else $error("degenerate result with nonzero content");

    // Neither unit is started while the multiplier has a product in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_busy |-> !mul_start && !div_start)
        else $error("unit started while multiplier busy");

    // Vertices are only taken with the sequencer idle; a third one starts the sequence and clears the slot counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        vtx_accept && third_vertex |=> state_reg == ttb_pkg::ST_LAUNCH && vertex_slot_reg == '0)
        else $error("third vertex did not start the sequence");

    // A result is only loaded when the output register is free, so a stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(tangent_x) && $stable(saturated))
        else $error("pending result overwritten");

endmodule
